[hdl/svq_pkg.sv]
// Shared types, constants and codes of the split virtqueue engine.
package svq_pkg;

	localparam int QUEUE_MAX_DEF = 256;
	localparam int CHAIN_MAX_DEF = 16;
	localparam int IDX_W         = 16;
	localparam int CFG_W         = 9;
	localparam int IN_DATA_W     = 168;
	localparam int OUT_DATA_W    = 184;

	typedef enum logic [2:0] {
		K_WR_DESC   = 3'd0,
		K_WR_AVAIL  = 3'd1,
		K_WR_AIDX   = 3'd2,
		K_WR_UFLAGS = 3'd3,
		K_POP       = 3'd4,
		K_PUSH      = 3'd5,
		K_NOTIFY    = 3'd6,
		K_NONE      = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_BAD_INDEX = 3'd2,
		ST_TOO_LONG  = 3'd3,
		ST_NOT_READY = 3'd4
	} status_t;

	typedef enum logic {
		REG_QUEUE_SIZE  = 1'b0,
		REG_QUEUE_READY = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_MOD, S_AVAIL, S_WALK, S_DESC, S_EMIT_RD, S_EMIT, S_RESULT
	} state_t;

	typedef struct packed {
		logic [63:0] addr;
		logic [31:0] len;
		logic [15:0] flags;
		logic [15:0] link;
	} desc_t;

	// Result word, highest member first so that status lands in the low bits.
	typedef struct packed {
		logic [6:0]  pad;
		logic        work_pending;
		logic        irq;
		logic [15:0] used_count;
		logic [7:0]  used_slot;
		logic [3:0]  chain_pos;
		logic [15:0] out_next;
		logic [15:0] out_flags;
		logic [31:0] out_len;
		logic [63:0] out_addr;
		logic [15:0] head;
		status_t     status;
	} result_t;

endpackage

[hdl/split_virtqueue_engine.sv]
// A register-style write (descriptor, ring slot, index, flags) is taken while idle and
// leaves the engine idle. A push goes from the check state through the bit-serial
// remainder unit (16 shift steps, then a done strobe), reducing the used index modulo
// the queue size, to the result state. A notify, an empty pop and any item refused as
// not ready go from the check state straight to the result state. A pop reduces the
// next available index in the same unit, reads the head from the available ring, walks
// the chain through the descriptor memory's single read port, then reads each
// descriptor back and emits it. Results pass through one output register, so a
// stalled consumer only holds the engine once a further result is ready.
module split_virtqueue_engine #(
	parameter int QUEUE_MAX = svq_pkg::QUEUE_MAX_DEF,
	parameter int CHAIN_MAX = svq_pkg::CHAIN_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// slot, buf_addr, buf_len, desc_flags, next_index, ring_value, used_id
	input  logic [svq_pkg::IN_DATA_W-1:0]     s_tdata,
	// kind
	input  logic [2:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status, head, out_addr, out_len, out_flags, out_next, chain_pos, used_slot,
	// used_count, irq, work_pending, zero fill
	output logic [svq_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [svq_pkg::CFG_W-1:0]         cfg_data
);
	import svq_pkg::*;

	localparam int QW = $clog2(QUEUE_MAX+1);
	localparam int AW = $clog2(QUEUE_MAX);
	localparam int CW = $clog2(CHAIN_MAX+1);
	localparam int PW = (CHAIN_MAX > 1) ? $clog2(CHAIN_MAX) : 1;

	state_t state_q, state_d;

	logic [QW-1:0]    qsize_q;
	logic             qready_q;
	logic [IDX_W-1:0] avail_idx_q, next_avail_q, uring_idx_q, used_flags_q;
	logic             irq_pend_q;

	kind_t            kind_q;
	logic [31:0]      len_q;
	logic [IDX_W-1:0] uid_q, head_q, idx_q;
	logic [AW-1:0]    uslot_q;
	status_t          st_q;
	logic [CW-1:0]    cnt_q;
	logic [PW-1:0]    pos_q;
	logic [AW-1:0]    scratch [CHAIN_MAX];

	result_t res_q, res_d;
	logic    out_valid_q, last_q, res_last;
	logic    res_free;

	logic          acc;
	kind_t         in_kind;
	logic [7:0]    in_slot;
	logic [IDX_W-1:0] in_ring;

	logic          desc_we, desc_re, av_we, av_re;
	logic [AW-1:0] desc_raddr, av_raddr, mod_rem;
	desc_t         desc_wdata, desc_rdata;
	logic [IDX_W-1:0] av_rdata;
	logic          mod_start, mod_done;
	logic          slot_ok;

	// Decoded control of the sequencer.
	logic idx_bad, chain_full, is_empty, emit_done;
	logic res_load, walk_step, desc_follow, desc_finish;

	assign acc      = s_tvalid && s_tready;
	assign in_kind  = kind_t'(s_tuser);
	assign in_slot  = s_tdata[7:0];
	assign in_ring  = s_tdata[151:136];
	assign slot_ok  = 32'(in_slot) < QUEUE_MAX;
	assign res_free = !out_valid_q || m_tready;

	assign desc_wdata = '{addr: s_tdata[71:8], len: s_tdata[103:72],
		flags: s_tdata[119:104], link: s_tdata[135:120]};
	assign desc_we = acc && in_kind == K_WR_DESC && slot_ok;
	assign av_we   = acc && in_kind == K_WR_AVAIL && slot_ok;

	assign idx_bad    = {1'b0, idx_q} >= (IDX_W+1)'(qsize_q);
	assign chain_full = cnt_q == CW'(CHAIN_MAX);
	assign is_empty   = next_avail_q == avail_idx_q;
	assign emit_done  = CW'(pos_q) + 1'b1 == cnt_q;

	svq_mem #(.QUEUE_MAX(QUEUE_MAX)) u_mem (
		.clk        (clk),
		.desc_we    (desc_we),
		.desc_waddr (AW'(in_slot)),
		.desc_wdata (desc_wdata),
		.desc_re    (desc_re),
		.desc_raddr (desc_raddr),
		.desc_rdata (desc_rdata),
		.av_we      (av_we),
		.av_waddr   (AW'(in_slot)),
		.av_wdata   (in_ring),
		.av_re      (av_re),
		.av_raddr   (av_raddr),
		.av_rdata   (av_rdata)
	);

	svq_mod #(.QUEUE_MAX(QUEUE_MAX)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend ((kind_q == K_POP) ? next_avail_q : uring_idx_q),
		.divisor  (qsize_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:
				if (acc && (in_kind == K_POP || in_kind == K_PUSH || in_kind == K_NOTIFY))
					state_d = S_CHECK;
			S_CHECK:
				if (!qready_q || kind_q == K_NOTIFY || (kind_q == K_POP && is_empty))
					state_d = S_RESULT;
				else
					state_d = S_MOD;
			S_MOD:
				if (mod_done)
					state_d = (kind_q == K_POP) ? S_AVAIL : S_RESULT;
			S_AVAIL:   state_d = S_WALK;
			S_WALK:    state_d = (idx_bad || chain_full) ? S_RESULT : S_DESC;
			S_DESC:    state_d = desc_rdata.flags[0] ? S_WALK : S_EMIT_RD;
			S_EMIT_RD: state_d = S_EMIT;
			S_EMIT:
				if (res_free)
					state_d = emit_done ? S_IDLE : S_EMIT_RD;
			S_RESULT:
				if (res_free)
					state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		s_tready    = 1'b0;
		mod_start   = 1'b0;
		av_re       = 1'b0;
		av_raddr    = mod_rem;
		desc_re     = 1'b0;
		desc_raddr  = AW'(idx_q);
		res_load    = 1'b0;
		res_last    = 1'b1;
		walk_step   = 1'b0;
		desc_follow = 1'b0;
		desc_finish = 1'b0;
		unique case (state_q)
			S_IDLE:  s_tready = 1'b1;
			S_CHECK: mod_start = qready_q && kind_q != K_NOTIFY
				&& !(kind_q == K_POP && is_empty);
			S_MOD:   av_re = mod_done && kind_q == K_POP;
			S_WALK: begin
				walk_step = !idx_bad && !chain_full;
				desc_re   = walk_step;
			end
			S_DESC: begin
				desc_follow = desc_rdata.flags[0];
				desc_finish = !desc_rdata.flags[0];
			end
			S_EMIT_RD: begin
				desc_re    = 1'b1;
				desc_raddr = scratch[pos_q];
			end
			S_EMIT: begin
				res_load = res_free;
				res_last = emit_done;
			end
			S_RESULT: res_load = res_free;
			default: ;
		endcase
	end

	// Result word.
	always_comb begin
		res_d = '0;
		res_d.work_pending = qready_q && !is_empty;
		res_d.used_count   = uring_idx_q;
		if (state_q == S_EMIT) begin
			res_d.status    = ST_OK;
			res_d.head      = head_q;
			res_d.out_addr  = desc_rdata.addr;
			res_d.out_len   = desc_rdata.len;
			res_d.out_flags = desc_rdata.flags;
			res_d.out_next  = desc_rdata.link;
			res_d.chain_pos = 4'(pos_q);
		end else begin
			res_d.status = st_q;
			if (st_q == ST_BAD_INDEX || st_q == ST_TOO_LONG)
				res_d.head = head_q;
			if (st_q == ST_OK && kind_q == K_PUSH) begin
				res_d.head       = uid_q;
				res_d.out_len    = len_q;
				res_d.used_slot  = 8'(uslot_q);
				res_d.used_count = uring_idx_q + 1'b1;
			end
			if (st_q == ST_OK && kind_q == K_NOTIFY)
				res_d.irq = !used_flags_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			qsize_q      <= QW'(QUEUE_MAX);
			qready_q     <= 1'b0;
			avail_idx_q  <= '0;
			next_avail_q <= '0;
			uring_idx_q  <= '0;
			used_flags_q <= '0;
			irq_pend_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
			pos_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (reg_idx_t'(cfg_index) == REG_QUEUE_SIZE) begin
					if (cfg_data != '0 && 32'(cfg_data) <= QUEUE_MAX)
						qsize_q <= QW'(cfg_data);
				end else begin
					qready_q <= cfg_data[0];
				end
			end
			if (acc && in_kind == K_WR_AIDX)
				avail_idx_q <= in_ring;
			if (acc && in_kind == K_WR_UFLAGS)
				used_flags_q <= in_ring;
			if (state_q == S_AVAIL)
				cnt_q <= '0;
			if (walk_step)
				cnt_q <= cnt_q + 1'b1;
			if (desc_finish) begin
				next_avail_q <= next_avail_q + 1'b1;
				pos_q        <= '0;
			end
			if (state_q == S_EMIT && res_free && !emit_done)
				pos_q <= pos_q + 1'b1;
			if (state_q == S_RESULT && res_free && st_q == ST_OK) begin
				if (kind_q == K_PUSH)
					uring_idx_q <= uring_idx_q + 1'b1;
				if (kind_q == K_NOTIFY && !used_flags_q[0])
					irq_pend_q <= 1'b1;
			end
			if (res_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// Item fields and walk registers.
	always_ff @(posedge clk) begin
		if (acc) begin
			kind_q <= in_kind;
			len_q  <= s_tdata[103:72];
			uid_q  <= s_tdata[167:152];
		end
		if (state_q == S_CHECK) begin
			if (!qready_q)
				st_q <= ST_NOT_READY;
			else if (kind_q == K_POP && is_empty)
				st_q <= ST_EMPTY;
			else
				st_q <= ST_OK;
		end
		if (state_q == S_MOD && mod_done)
			uslot_q <= mod_rem;
		if (state_q == S_AVAIL) begin
			idx_q  <= av_rdata;
			head_q <= av_rdata;
		end
		if (state_q == S_WALK) begin
			if (idx_bad)
				st_q <= ST_BAD_INDEX;
			else if (chain_full)
				st_q <= ST_TOO_LONG;
		end
		if (walk_step)
			scratch[cnt_q[PW-1:0]] <= AW'(idx_q);
		if (desc_follow)
			idx_q <= desc_rdata.link;
		if (res_load) begin
			res_q  <= res_d;
			last_q <= res_last;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = res_q;
	assign m_tlast   = last_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!out_valid_q || m_tready))
		else $error("result register overwritten while held");
	a_chain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CHAIN_MAX))
		else $error("chain count beyond limit");
	a_emit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> CW'(pos_q) < cnt_q)
		else $error("emit position beyond walked chain");
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !s_tready)
		else $error("input taken while an item is in progress");

endmodule

[hdl/svq_mod.sv]
// Bit-serial remainder unit: a 16-bit index modulo the queue size.
module svq_mod #(
	parameter int QUEUE_MAX = svq_pkg::QUEUE_MAX_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [svq_pkg::IDX_W-1:0]          dividend,
	input  logic [$clog2(QUEUE_MAX+1)-1:0]     divisor,
	output logic                               done,
	output logic [$clog2(QUEUE_MAX)-1:0]       rem
);
	import svq_pkg::*;

	localparam int QW = $clog2(QUEUE_MAX+1);
	localparam int AW = $clog2(QUEUE_MAX);
	localparam int SW = $clog2(IDX_W+1);

	logic [IDX_W-1:0] dvd_q;
	logic [QW-1:0]    rem_q;
	logic [SW-1:0]    step_q;
	logic             busy_q;
	logic             done_q;
	logic [QW:0]      trial;
	logic [QW:0]      trial_sub;

	always_comb begin
		trial     = {rem_q, dvd_q[IDX_W-1]};
		trial_sub = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SW'(IDX_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (trial >= {1'b0, divisor})
				rem_q <= trial_sub[QW-1:0];
			else
				rem_q <= trial[QW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = AW'(rem_q);

endmodule

[hdl/svq_mem.sv]
// Descriptor table and available ring memories, one write and one read port each.
module svq_mem #(
	parameter int QUEUE_MAX = svq_pkg::QUEUE_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           desc_we,
	input  logic [$clog2(QUEUE_MAX)-1:0]   desc_waddr,
	input  svq_pkg::desc_t                 desc_wdata,
	input  logic                           desc_re,
	input  logic [$clog2(QUEUE_MAX)-1:0]   desc_raddr,
	output svq_pkg::desc_t                 desc_rdata,
	input  logic                           av_we,
	input  logic [$clog2(QUEUE_MAX)-1:0]   av_waddr,
	input  logic [svq_pkg::IDX_W-1:0]      av_wdata,
	input  logic                           av_re,
	input  logic [$clog2(QUEUE_MAX)-1:0]   av_raddr,
	output logic [svq_pkg::IDX_W-1:0]      av_rdata
);
	import svq_pkg::*;

	desc_t            desc_mem [QUEUE_MAX];
	logic [IDX_W-1:0] av_mem   [QUEUE_MAX];

	always_ff @(posedge clk) begin
		if (desc_we)
			desc_mem[desc_waddr] <= desc_wdata;
		if (desc_re)
			desc_rdata <= desc_mem[desc_raddr];
	end

	always_ff @(posedge clk) begin
		if (av_we)
			av_mem[av_waddr] <= av_wdata;
		if (av_re)
			av_rdata <= av_mem[av_raddr];
	end

endmodule
